/* hw/rtl/sla_pkg.sv */
`timescale 1ns / 1ps

package sla_pkg;

   localparam int SHADOW_BYTES     = 4096;
   localparam int MAX_ACCESS_BYTES = 16;
   localparam int STEP_BYTES       = 4;
   localparam int ADDR_W           = 12;
   localparam int REGION_W         = 13;
   localparam int ENTRY_W          = 64;
   localparam int GEN_W            = 8;
   localparam int PC_W             = 24;
   localparam int BLOCK_W          = 22;
   localparam int ID_W             = 5;
   localparam int BYTES_W          = 5;
   localparam int STEP_W           = 3;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [GEN_W-1:0]    GEN_RESET    = 8'd1;
   localparam logic [REGION_W-1:0] REGION_RESET = 13'd4096;

   localparam logic [0:0] REG_GENERATION  = 1'b0;
   localparam logic [0:0] REG_REGION_SIZE = 1'b1;

   localparam logic ACT_ACCESS = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   localparam logic [1:0] SCOPE_THREAD = 2'd0;
   localparam logic [1:0] SCOPE_WARP   = 2'd1;
   localparam logic [1:0] SCOPE_BLOCK  = 2'd2;
   localparam logic [1:0] SCOPE_GRID   = 2'd3;

   typedef struct packed {
      logic               action;
      logic [ADDR_W-1:0]  byte_offset;
      logic [BYTES_W-1:0] access_bytes;
      logic [PC_W-1:0]    access_pc;
      logic [BLOCK_W-1:0] block_id;
      logic [ID_W-1:0]    warp_id;
      logic [ID_W-1:0]    lane_id;
   } req_word_type;

   typedef struct packed {
      logic [PC_W-1:0] dep_pc;
      logic [PC_W-1:0] prior_pc;
      logic [1:0]      scope;
      logic            miss;
      logic            last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic clear_req;
      logic first_ok;
      logic next_ok;
      logic clr_last;
   } stat_type;

   // Number of word steps in an access after saturation to the maximum size.
   function automatic logic [STEP_W-1:0] step_count(input logic [BYTES_W-1:0] bytes);
      logic [BYTES_W-1:0] sat;
      logic [BYTES_W:0]   rounded;
      sat     = (bytes > BYTES_W'(MAX_ACCESS_BYTES)) ? BYTES_W'(MAX_ACCESS_BYTES) : bytes;
      rounded = {1'b0, sat} + (BYTES_W+1)'(STEP_BYTES - 1);
      return rounded[STEP_W+1:2];
   endfunction

endpackage

/* hw/rtl/sla_ram.sv */
`timescale 1ns / 1ps

module sla_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/sla_ctrl.sv */
`timescale 1ns / 1ps

module sla_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sla_pkg::stat_type stat,
   output sla_pkg::cmd_type  cmd
);

   sla_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sla_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         sla_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = sla_pkg::ST_IDLE;
            end
         end
         sla_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (stat.clear_req) begin
                  state_in = sla_pkg::ST_CLEAR;
               end else begin
                  cmd.load = 1'b1;
                  if (stat.first_ok) begin
                     state_in = sla_pkg::ST_RUN;
                  end
               end
            end
         end
         sla_pkg::ST_RUN: begin
            if (out_free) begin
               cmd.advance  = 1'b1;
               rsp_valid_in = 1'b1;
               if (!stat.next_ok) begin
                  state_in = sla_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sla_pkg::ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/sla_dp.sv */
`timescale 1ns / 1ps

module sla_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sla_pkg::req_word_type               req_word,
   input  logic [sla_pkg::GEN_W-1:0]           generation,
   input  logic [sla_pkg::REGION_W-1:0]        region_size,
   input  sla_pkg::cmd_type                    cmd,
   output sla_pkg::stat_type                   stat,
   output sla_pkg::rsp_word_type               rsp_word
);

   logic [sla_pkg::REGION_W-1:0] addr_ff, addr_in;
   logic [sla_pkg::STEP_W-1:0]   left_ff, left_in;
   logic [sla_pkg::PC_W-1:0]     pc_ff, pc_in;
   logic [sla_pkg::BLOCK_W-1:0]  blk_ff, blk_in;
   logic [sla_pkg::ID_W-1:0]     warp_ff, warp_in;
   logic [sla_pkg::ID_W-1:0]     lane_ff, lane_in;
   logic [sla_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   sla_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   logic [sla_pkg::REGION_W-1:0] limit;
   logic [sla_pkg::REGION_W-1:0] next_addr;
   logic [sla_pkg::ENTRY_W-1:0]  old_entry;
   logic [sla_pkg::ENTRY_W-1:0]  new_entry;
   logic                         ram_we;
   logic [sla_pkg::ADDR_W-1:0]   ram_waddr;
   logic [sla_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [sla_pkg::ADDR_W-1:0]   ram_raddr;
   logic                         cold;

   sla_ram #(
      .WIDTH(sla_pkg::ENTRY_W),
      .DEPTH(sla_pkg::SHADOW_BYTES)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(old_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      left_ff     <= left_in;
      pc_ff       <= pc_in;
      blk_ff      <= blk_in;
      warp_ff     <= warp_in;
      lane_ff     <= lane_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      limit = (region_size > sla_pkg::REGION_W'(sla_pkg::SHADOW_BYTES)) ?
              sla_pkg::REGION_W'(sla_pkg::SHADOW_BYTES) : region_size;
      next_addr = addr_ff + sla_pkg::REGION_W'(sla_pkg::STEP_BYTES);

      stat.clear_req = (req_word.action == sla_pkg::ACT_CLEAR);
      stat.first_ok  = (sla_pkg::step_count(req_word.access_bytes) != '0) &&
                       ({1'b0, req_word.byte_offset} < limit);
      stat.next_ok   = (left_ff > sla_pkg::STEP_W'(1)) && (next_addr < limit);
      stat.clr_last  = (clr_addr_ff == sla_pkg::ADDR_W'(sla_pkg::SHADOW_BYTES - 1));

      new_entry = {blk_ff, warp_ff, lane_ff, generation, pc_ff};
      cold      = (old_entry == '0) || (old_entry[31:24] != generation);

      rsp_word_in.dep_pc = pc_ff;
      rsp_word_in.miss   = cold;
      rsp_word_in.last   = !stat.next_ok;
      if (cold) begin
         rsp_word_in.prior_pc = '0;
         rsp_word_in.scope    = sla_pkg::SCOPE_THREAD;
      end else begin
         rsp_word_in.prior_pc = old_entry[23:0];
         if (old_entry[63:42] != blk_ff) begin
            rsp_word_in.scope = sla_pkg::SCOPE_GRID;
         end else if (old_entry[41:37] != warp_ff) begin
            rsp_word_in.scope = sla_pkg::SCOPE_BLOCK;
         end else if (old_entry[36:32] != lane_ff) begin
            rsp_word_in.scope = sla_pkg::SCOPE_WARP;
         end else begin
            rsp_word_in.scope = sla_pkg::SCOPE_THREAD;
         end
      end
      if (!cmd.advance) begin
         rsp_word_in = rsp_word_ff;
      end

      addr_in     = addr_ff;
      left_in     = left_ff;
      pc_in       = pc_ff;
      blk_in      = blk_ff;
      warp_in     = warp_ff;
      lane_in     = lane_ff;
      clr_addr_in = clr_addr_ff;
      if (cmd.load) begin
         addr_in = {1'b0, req_word.byte_offset};
         left_in = sla_pkg::step_count(req_word.access_bytes);
         pc_in   = req_word.access_pc;
         blk_in  = req_word.block_id;
         warp_in = req_word.warp_id;
         lane_in = req_word.lane_id;
      end else if (cmd.advance) begin
         addr_in = next_addr;
         left_in = left_ff - sla_pkg::STEP_W'(1);
      end
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + sla_pkg::ADDR_W'(1);
      end

      ram_we    = cmd.clr_step || cmd.advance;
      ram_waddr = cmd.clr_step ? clr_addr_ff : addr_ff[sla_pkg::ADDR_W-1:0];
      ram_wdata = cmd.clr_step ? '0 : new_entry;
      if (cmd.load) begin
         ram_raddr = req_word.byte_offset;
      end else if (cmd.advance) begin
         ram_raddr = next_addr[sla_pkg::ADDR_W-1:0];
      end else begin
         ram_raddr = addr_ff[sla_pkg::ADDR_W-1:0];
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

/* hw/rtl/shadow_last_access_tracker.sv */
// An accepted access then makes one word step (up to four) per cycle while the response
// output is free, each step a read-modify-write of the single-port-write shadow RAM; each
// response word is built from the registered RAM read and is itself registered.
// A clear item, and reset itself, start a sweep that zeroes every entry of the shadow RAM
// one entry per cycle; req_ready stays low during the sweep while CSR writes are still taken.
// Reset is synchronous and active high and returns both registers to their reset values.
`timescale 1ns / 1ps

module shadow_last_access_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sla_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sla_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sla_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sla_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sla_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   logic [sla_pkg::GEN_W-1:0]    gen_ff, gen_in;
   logic [sla_pkg::REGION_W-1:0] region_ff, region_in;
   logic                         csr_write;
   sla_pkg::cmd_type             cmd;
   sla_pkg::stat_type            stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff    <= sla_pkg::GEN_RESET;
         region_ff <= sla_pkg::REGION_RESET;
      end else begin
         gen_ff    <= gen_in;
         region_ff <= region_in;
      end
   end

   always_comb begin
      csr_write = csr_psel && csr_penable && csr_pwrite;
      gen_in    = gen_ff;
      region_in = region_ff;
      case (csr_paddr[2])
         sla_pkg::REG_GENERATION: begin
            csr_prdata = {{(sla_pkg::CSR_DATA_W - sla_pkg::GEN_W){1'b0}}, gen_ff};
            if (csr_write) begin
               gen_in = csr_pwdata[sla_pkg::GEN_W-1:0];
            end
         end
         sla_pkg::REG_REGION_SIZE: begin
            csr_prdata = {{(sla_pkg::CSR_DATA_W - sla_pkg::REGION_W){1'b0}}, region_ff};
            if (csr_write) begin
               region_in = csr_pwdata[sla_pkg::REGION_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;

   sla_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   sla_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .generation (gen_ff),
      .region_size(region_ff),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_word   (rsp_word)
   );

endmodule

/* hw/rtl/sla_checker.sv */
`timescale 1ns / 1ps

module sla_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input sla_pkg::req_word_type          req_word,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input sla_pkg::rsp_word_type          rsp_word,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pready
);

   // A pending word is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("pending response word changed before it was taken");

   // Reset always starts the clearing sweep.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted right after reset");

   // A clear word starts the sweep and blocks the request channel.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.action == sla_pkg::ACT_CLEAR |=> !req_ready)
      else $error("request channel open right after a clear word");

   // A zero-size access produces no work and no response.
   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.action == sla_pkg::ACT_ACCESS &&
      req_word.access_bytes == '0 |=> req_ready)
      else $error("zero-size access kept the block busy");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable |-> csr_pready)
      else $error("CSR access stalled");

endmodule

bind shadow_last_access_tracker sla_checker u_sla_checker (.*);
